>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the tilt filter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> hdl/tcf_pkg.sv
// Types, widths and constants of the tilt complementary filter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package tcf_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_GYRO_GAIN   = 1'b0;
  localparam logic REG_BLEND_ALPHA = 1'b1;

  // Datapath widths.
  localparam int XW   = 30;  // CORDIC x/y (sample << 16 with gain growth)
  localparam int AW   = 25;  // CORDIC angle accumulator, Q16.16 degrees
  localparam int IDXW = 5;   // CORDIC step index
  localparam int GW   = 42;  // angle plus gyro rate
  localparam int MA   = 18;  // multiplier operand a (signed)
  localparam int MB   = 33;  // multiplier operand b (signed)
  localparam int PW   = MA + MB;
  localparam int SW   = 60;  // blend accumulator

  localparam int ATAN_LEN = 24;

  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd64225;
  localparam logic [31:0] GAIN_RESET  = 32'd1468;

  // atan(2^-i) in degrees, Q16.16, rounded to nearest.
  localparam logic [21:0] ATAN_DEG_Q16 [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_TILT,
    ST_RATE,
    ST_GPATH,
    ST_MLO,
    ST_MHI,
    ST_MAP,
    ST_SUM,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_RATE,
    MUL_GLO,
    MUL_GHI,
    MUL_APATH
  } mul_sel_t;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_INIT,
    SUM_ADD_HI,
    SUM_ADD
  } sum_op_t;

  typedef struct packed {
    logic            load;
    logic            step_en;
    logic [IDXW-1:0] step_idx;
    logic            offset_load;
    logic            mul_en;
    mul_sel_t        mul_sel;
    logic            gpath_load;
    sum_op_t         sum_op;
    logic            angle_load;
    logic            out_load;
  } tcf_cmd_t;

  typedef struct packed {
    logic op_update;
    logic out_free;
  } tcf_status_t;

endpackage

`default_nettype wire

>>> hdl/tcf_ctrl.sv
// Sequencer of the tilt filter: walks the CORDIC steps and the blend schedule.
// Depends on tcf_pkg.
`default_nettype none

module tcf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tcf_pkg::tcf_status_t status,
  output tcf_pkg::tcf_cmd_t        cmd
);
  import tcf_pkg::*;

  localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [IDXW-1:0] LAST_STEP = IDXW'(STEPS_EFF - 1);

  state_t          state_r, state_nxt;
  logic [IDXW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.mul_sel      = MUL_RATE;
    cmd.sum_op       = SUM_HOLD;
    cmd.step_idx     = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd.step_en = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_TILT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TILT: begin
        if (status.op_update) begin
          state_nxt = ST_RATE;
        end else begin
          cmd.offset_load = 1'b1;
          state_nxt       = ST_DONE;
        end
      end
      ST_RATE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RATE;
        state_nxt   = ST_GPATH;
      end
      ST_GPATH: begin
        cmd.gpath_load = 1'b1;
        state_nxt      = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GLO;
        state_nxt   = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GHI;
        cmd.sum_op  = SUM_INIT;
        state_nxt   = ST_MAP;
      end
      ST_MAP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_APATH;
        cmd.sum_op  = SUM_ADD_HI;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_op = SUM_ADD;
        state_nxt  = ST_SAT;
      end
      ST_SAT: begin
        cmd.angle_load = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tcf_dp.sv
// Datapath of the tilt filter: CORDIC vectoring unit, shared multiplier,
// blend accumulator, filter state, configuration and output registers. Uses tcf_pkg.
`default_nettype none

module tcf_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tcf_pkg::tcf_cmd_t   cmd,
  output tcf_pkg::tcf_status_t     status,
  input  wire logic                in_operation,
  input  wire logic signed [15:0]  in_accel_y_word,
  input  wire logic signed [15:0]  in_accel_z_word,
  input  wire logic signed [15:0]  in_gyro_y_word,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic signed [31:0]       out_tilt_angle
);
  import tcf_pkg::*;

  // Configuration.
  logic [31:0] gain_r;
  logic [16:0] alpha_r, beta_r;
  logic [16:0] alpha_wr;

  // Item registers.
  logic               op_r;
  logic signed [15:0] gyro_r;
  logic               zero_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [AW-1:0] acc_r;

  // Filter state.
  logic signed [31:0]   angle_r;
  logic signed [AW-1:0] offset_r;

  // Blend datapath.
  logic signed [PW-1:0]   prod_r;
  logic signed [GW-1:0]   gpath_r;
  logic signed [AW:0]     apath_r;
  logic signed [SW-1:0]   sum_r;

  logic               out_valid_r;
  logic signed [31:0] out_data_r;

  // Load-time values.
  logic signed [11:0]   ys, zs;
  logic signed [XW-1:0] xz, yy;
  logic signed [XW-1:0] x_ld, y_ld;
  logic signed [AW-1:0] acc_ld;

  // CORDIC step.
  logic signed [XW-1:0] xs, yv;
  logic signed [AW-1:0] atan_v;

  logic signed [AW-1:0] tilt;
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [PW-1:0] prod_nxt;
  logic signed [SW-1:0] prod_ext, rate_w, gsum_w;
  logic signed [SW-17:0] blend_w;
  logic signed [31:0]    sat_w;

  // Configuration writes; alpha is clamped to one when written.
  assign alpha_wr = (cfg_wdata[16:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      alpha_r <= ALPHA_RESET;
      beta_r  <= ALPHA_ONE - ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GYRO_GAIN: begin
          gain_r <= cfg_wdata;
        end
        REG_BLEND_ALPHA: begin
          alpha_r <= alpha_wr;
          beta_r  <= ALPHA_ONE - alpha_wr;
        end
        default: begin
        end
      endcase
    end
  end

  // Sample scaling and pre-rotation into the right half plane.
  assign ys = in_accel_y_word[15:4];
  assign zs = in_accel_z_word[15:4];
  assign xz = {{(XW-28){zs[11]}}, zs, 16'h0000};
  assign yy = {{(XW-28){ys[11]}}, ys, 16'h0000};

  always_comb begin
    x_ld   = xz;
    y_ld   = yy;
    acc_ld = '0;
    if (zs[11]) begin
      if (!ys[11]) begin
        x_ld   = yy;
        y_ld   = -xz;
        acc_ld = AW'(90 * 65536);
      end else begin
        x_ld   = -yy;
        y_ld   = xz;
        acc_ld = -AW'(90 * 65536);
      end
    end
  end

  assign xs     = x_r >>> cmd.step_idx;
  assign yv     = y_r >>> cmd.step_idx;
  assign atan_v = AW'(ATAN_DEG_Q16[cmd.step_idx]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      gyro_r <= in_gyro_y_word;
      zero_r <= (ys == '0) && (zs == '0);
      x_r    <= x_ld;
      y_r    <= y_ld;
      acc_r  <= acc_ld;
    end else if (cmd.step_en) begin
      if (!y_r[XW-1]) begin
        x_r   <= x_r + yv;
        y_r   <= y_r - xs;
        acc_r <= acc_r + atan_v;
      end else begin
        x_r   <= x_r - yv;
        y_r   <= y_r + xs;
        acc_r <= acc_r - atan_v;
      end
    end
  end

  assign tilt = zero_r ? '0 : acc_r;

  // Shared multiplier, one product per cycle.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RATE: begin
        ma = {{(MA-16){gyro_r[15]}}, gyro_r};
        mb = {1'b0, gain_r};
      end
      MUL_GLO: begin
        ma = {1'b0, alpha_r};
        mb = {{(MB-21){1'b0}}, gpath_r[20:0]};
      end
      MUL_GHI: begin
        ma = {1'b0, alpha_r};
        mb = {{(MB-(GW-21)){gpath_r[GW-1]}}, gpath_r[GW-1:21]};
      end
      MUL_APATH: begin
        ma = {1'b0, beta_r};
        mb = {{(MB-AW-1){apath_r[AW]}}, apath_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = ma * mb;
  assign prod_ext = SW'(prod_r);
  assign rate_w   = (prod_ext + SW'(128)) >>> 8;
  assign gsum_w   = rate_w + SW'(angle_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.gpath_load) begin
      gpath_r <= GW'(gsum_w);
      apath_r <= (AW+1)'(tilt) - (AW+1)'(offset_r);
    end
    unique case (cmd.sum_op)
      SUM_HOLD:   sum_r <= sum_r;
      SUM_INIT:   sum_r <= prod_ext + SW'(32768);
      SUM_ADD_HI: sum_r <= sum_r + (prod_ext <<< 21);
      SUM_ADD:    sum_r <= sum_r + prod_ext;
      default:    sum_r <= sum_r;
    endcase
  end

  // Round-down shift by 16 and saturation to 32 bits.
  assign blend_w = sum_r[SW-1:16];

  always_comb begin
    if ((blend_w[SW-17:31] == '0) || (blend_w[SW-17:31] == '1)) begin
      sat_w = blend_w[31:0];
    end else if (blend_w[SW-17]) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r  <= '0;
      offset_r <= '0;
    end else begin
      if (cmd.angle_load) begin
        angle_r <= sat_w;
      end
      if (cmd.offset_load) begin
        offset_r <= tilt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= angle_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tilt_angle = out_data_r;

  assign status.op_update = op_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> hdl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: sequencer plus datapath.
// Depends on tcf_pkg, tcf_ctrl, tcf_dp and assert_macros.svh.
//
// Usage. Each input transfer carries an operation bit and raw accelerometer
// Y/Z words plus a gyro Y word. Both accelerometer words are taken as 12-bit
// samples, and their tilt atan2(y, z) in degrees is found by a vectoring
// CORDIC that does one iteration per cycle. A calibrate transfer stores that
// tilt as the offset; an update transfer blends the gyro-integrated angle with
// the offset-corrected tilt. Every input transfer yields exactly one output
// transfer carrying the current angle estimate in signed Q16.16 degrees.
// After the CORDIC iterations a calibrate stores the offset and goes to the
// output, while an update first runs the blend, which takes four passes
// through one shared 18x33 multiplier. One item is in work at a time, so the
// next input transfer is taken only once the last result is in the output
// register.
// The result sits in an output register; the next input transfer is taken
// while it waits. If the receiver stalls for longer than an item takes, the
// sequencer holds the next finished result until the output register frees.
// The synchronous reset clears the angle and offset to zero and loads the
// gain and alpha registers with their defaults. Configuration writes take
// effect at once and are expected only while no item is in work.
`default_nettype none
`include "assert_macros.svh"

module tilt_complementary_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic signed [15:0] in_accel_y_word,
  input  wire logic signed [15:0] in_accel_z_word,
  input  wire logic signed [15:0] in_gyro_y_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_tilt_angle,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import tcf_pkg::*;

  localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  tcf_cmd_t    cmd;
  tcf_status_t status;

  // The sequencer only issues commands; the filter arithmetic and state live in
  // the datapath.
  tcf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  tcf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_operation   (in_operation),
    .in_accel_y_word(in_accel_y_word),
    .in_accel_z_word(in_accel_z_word),
    .in_gyro_y_word (in_gyro_y_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_tilt_angle (out_tilt_angle)
  );

  // Only one item is in work: accepting one closes the input side.
  `ASSERT_NEXT(a_single_item, clk, rst_n, in_valid && in_ready, !in_ready)
  // A result is never written over one that has not been taken.
  `ASSERT_IMPL(a_out_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || out_ready)
  // The step index stays inside the arctangent table in use.
  `ASSERT_IMPL(a_step_range, clk, rst_n, cmd.step_en, cmd.step_idx < IDXW'(STEPS_EFF))

endmodule

`default_nettype wire
